// ===== sv/hsvca_pkg.sv =====
// Shared types, constants and helpers for the HSV color adjust unit.
`timescale 1ns / 1ps
package hsvca_pkg;

    localparam int FRAC_BITS = 12;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam logic [FX_W-1:0] FX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // long-division lanes: 8-bit divisor, 14 quotient bits, one bit per cell
    localparam int REM_W = 8;
    localparam int QUO_W = 14;
    localparam int DVD_W = REM_W + QUO_W;

    // hue in Q9.8 degrees
    localparam int HUE_W = 17;
    localparam logic [HUE_W-1:0] HUE_SECTOR = 17'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL   = 17'd92160;

    // x / 100 as (x * RECIP100) >> RECIP100_SH, exact for x < 2^22
    localparam int RECIP100_SH = 29;
    localparam logic [22:0] RECIP100 = 23'd5368710;
    // x / 15 as (x * RECIP15) >> RECIP15_SH, exact for x < 74898
    localparam int RECIP15_SH = 20;
    localparam logic [16:0] RECIP15 = 17'd69906;
    // x / 255 as (x * RECIP255) >> RECIP255_SH, exact for x < 2^21
    localparam int RECIP255_SH = 29;
    localparam logic [21:0] RECIP255 = 22'd2105377;

    localparam int CFG_W = 10;

    typedef enum logic [1:0] {
        CFG_HUE_OFFSET,
        CFG_SAT_PCT,
        CFG_VAL_PCT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    typedef enum logic [2:0] {
        SEC_RY,
        SEC_YG,
        SEC_GC,
        SEC_CB,
        SEC_BM,
        SEC_MR
    } hue_sector_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] nlow;
        logic [QUO_W-1:0] quo;
        logic [REM_W-1:0] dvs;
    } div_lane_t;

    typedef struct packed {
        logic [FX_W-1:0] v;
        max_sel_t        sel;
        logic            neg;
        logic            flat;
        logic            dark;
    } div_side_t;

    typedef struct packed {
        div_lane_t sat;
        div_lane_t hue;
        div_side_t side;
    } div_word_t;

    // ceil(mx * ONE / 255)
    function automatic logic [FX_W-1:0] value_of_max(input logic [7:0] mx);
        logic [20:0] num;
        logic [42:0] prod;
        num  = (21'(mx) << FRAC_BITS) + 21'd254;
        prod = 43'(num) * 43'(RECIP255);
        return prod[RECIP255_SH +: FX_W];
    endfunction

endpackage

// ===== sv/hsv_color_adjust_unit.sv =====
// HSV color adjust unit: RGB pixel in, hue/saturation/value adjusted RGB pixel out.
//
// Input channel: red_in/green_in/blue_in with in_valid; a transfer happens on a
// clock edge with in_valid high and in_stall low. Output channel: red_out/
// green_out/blue_out with out_valid, transferred when out_stall is low.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 hue offset,
// 1 saturation percent, 2 value percent); other indexes are ignored. Write
// only while the pipeline is empty.
// The pipeline has one input stage, a chain of 14 divider cells that each
// retire one quotient bit of the saturation and hue divisions, and seven
// stages for hue wrap, scaling, sector fraction and the back conversion.
// One pixel per clock when not stalled; every stage holds its own valid bit.
// When the receiver stalls, stages fill up behind the output register and
// bubbles are squeezed out; in_stall rises only once every stage is full.
// Reset clears all valid bits and sets the three registers to zero.
`timescale 1ns / 1ps
module hsv_color_adjust_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    red_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    blue_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    red_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    blue_out,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [hsvca_pkg::CFG_W-1:0]   cfg_data
);

    localparam int FB   = hsvca_pkg::FRAC_BITS;
    localparam int FW   = hsvca_pkg::FX_W;
    localparam int HW   = hsvca_pkg::HUE_W;
    localparam int QW   = hsvca_pkg::QUO_W;
    localparam int DW   = hsvca_pkg::DVD_W;
    localparam int RW   = hsvca_pkg::REM_W;
    localparam int CW   = hsvca_pkg::CFG_W;

    // ---------------- configuration ----------------
    logic signed [CW-1:0] hue_off_reg;
    logic signed [CW-1:0] sat_pct_reg;
    logic signed [CW-1:0] val_pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_off_reg <= '0;
            sat_pct_reg <= '0;
            val_pct_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (hsvca_pkg::cfg_reg_t'(cfg_index))
                hsvca_pkg::CFG_HUE_OFFSET: hue_off_reg <= cfg_data;
                hsvca_pkg::CFG_SAT_PCT:    sat_pct_reg <= cfg_data;
                hsvca_pkg::CFG_VAL_PCT:    val_pct_reg <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // ---------------- ready chain ----------------
    logic vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    logic vld_e_reg, vld_f_reg, vld_g_reg, vld_h_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f, rdy_g, rdy_h;

    logic                 chain_vld [QW+1];
    logic                 chain_rdy [QW+1];
    hsvca_pkg::div_word_t chain_word [QW+1];

    assign rdy_h = !vld_h_reg || !out_stall;
    assign rdy_g = !vld_g_reg || rdy_h;
    assign rdy_f = !vld_f_reg || rdy_g;
    assign rdy_e = !vld_e_reg || rdy_f;
    assign rdy_d = !vld_d_reg || rdy_e;
    assign rdy_c = !vld_c_reg || rdy_d;
    assign rdy_b = !vld_b_reg || rdy_c;
    assign chain_rdy[QW] = rdy_b;
    assign rdy_a = !vld_a_reg || chain_rdy[0];
    assign in_stall = !rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
            vld_h_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a) vld_a_reg <= in_valid;
            if (rdy_b) vld_b_reg <= chain_vld[QW];
            if (rdy_c) vld_c_reg <= vld_b_reg;
            if (rdy_d) vld_d_reg <= vld_c_reg;
            if (rdy_e) vld_e_reg <= vld_d_reg;
            if (rdy_f) vld_f_reg <= vld_e_reg;
            if (rdy_g) vld_g_reg <= vld_f_reg;
            if (rdy_h) vld_h_reg <= vld_g_reg;
        end
    end

    // ---------------- stage A: max/min, division setup ----------------
    hsvca_pkg::div_word_t st_a_reg;
    hsvca_pkg::div_word_t st_a_next;
    logic [7:0]           mx, mn, delta, mag;
    logic signed [8:0]    dsgn;
    logic [DW-1:0]        n_sat, n_hue;
    hsvca_pkg::max_sel_t  sel;

    always_comb
    begin
        mx = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx)  mx = blue_in;
        mn = red_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn)  mn = blue_in;
        delta = mx - mn;

        // ties: red over green over blue
        if (red_in == mx)
        begin
            sel  = hsvca_pkg::MAX_RED;
            dsgn = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
        end
        else if (green_in == mx)
        begin
            sel  = hsvca_pkg::MAX_GREEN;
            dsgn = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
        end
        else
        begin
            sel  = hsvca_pkg::MAX_BLUE;
            dsgn = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
        end
        mag = dsgn[8] ? 8'(-dsgn) : dsgn[7:0];

        n_sat = (mx == 8'd0) ? '0 : (DW'(delta) << FB) + DW'(mx) - DW'(1);
        // |diff| * 15360 = |diff| * 2^14 - |diff| * 2^10
        n_hue = (DW'(mag) << 14) - (DW'(mag) << 10);

        st_a_next.sat.rem  = n_sat[DW-1:QW];
        st_a_next.sat.nlow = n_sat[QW-1:0];
        st_a_next.sat.quo  = '0;
        st_a_next.sat.dvs  = (mx == 8'd0) ? RW'(1) : mx;
        st_a_next.hue.rem  = n_hue[DW-1:QW];
        st_a_next.hue.nlow = n_hue[QW-1:0];
        st_a_next.hue.quo  = '0;
        st_a_next.hue.dvs  = (delta == 8'd0) ? RW'(1) : delta;
        st_a_next.side.v    = hsvca_pkg::value_of_max(mx);
        st_a_next.side.sel  = sel;
        st_a_next.side.neg  = dsgn[8];
        st_a_next.side.flat = (delta == 8'd0);
        st_a_next.side.dark = (mx == 8'd0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            st_a_reg <= st_a_next;
        end
    end

    // ---------------- divider cell chain ----------------
    assign chain_vld[0]  = vld_a_reg;
    assign chain_word[0] = st_a_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_cell
        hsvca_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (chain_vld[i]),
            .in_word  (chain_word[i]),
            .down_rdy (chain_rdy[i+1]),
            .up_rdy   (chain_rdy[i]),
            .out_vld  (chain_vld[i+1]),
            .out_word (chain_word[i+1])
        );
    end

    // ---------------- stage B: hue assembly, scale products ----------------
    hsvca_pkg::div_word_t w;
    logic [FW-1:0]        s_raw;
    logic [QW:0]          hmag;
    logic [HW-1:0]        hbase, h0_next;
    logic signed [CW:0]   ks, kv;
    logic [22:0]          sp_next, vp_next;

    logic [HW-1:0] h0_reg;
    logic [22:0]   sp_reg, vp_reg;
    logic          sz_reg, vz_reg;

    assign w = chain_word[QW];

    always_comb
    begin
        s_raw = w.side.dark ? '0 : w.sat.quo[FW-1:0];
        // floor for a negative difference: round the magnitude up
        hmag  = (QW+1)'(w.hue.quo) + (QW+1)'(w.side.neg && (w.hue.rem != '0));
        unique case (w.side.sel)
            hsvca_pkg::MAX_RED:   hbase = w.side.neg ? hsvca_pkg::HUE_FULL : '0;
            hsvca_pkg::MAX_GREEN: hbase = HW'(2 * hsvca_pkg::HUE_SECTOR);
            default:              hbase = HW'(4 * hsvca_pkg::HUE_SECTOR);
        endcase
        if (w.side.flat)
            h0_next = '0;
        else if (w.side.neg)
            h0_next = hbase - HW'(hmag);
        else
            h0_next = hbase + HW'(hmag);

        ks = (CW+1)'(signed'(11'sd100)) + (CW+1)'(sat_pct_reg);
        kv = (CW+1)'(signed'(11'sd100)) + (CW+1)'(val_pct_reg);
        sp_next = 23'(s_raw) * 23'(ks[CW-1:0]);
        vp_next = 23'(w.side.v) * 23'(kv[CW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_b && chain_vld[QW])
        begin
            h0_reg <= h0_next;
            sp_reg <= sp_next;
            vp_reg <= vp_next;
            sz_reg <= (ks <= 0);
            vz_reg <= (kv <= 0);
        end
    end

    // ---------------- stage C: hue offset and wrap, divide by 100 ----------------
    logic signed [19:0] h1, h2, off_ext;
    logic [45:0]        s_mul, v_mul;
    logic [16:0]        s_div, v_div;
    logic [HW-1:0]      hc_next;
    logic [FW-1:0]      sc_next, vc_next;

    logic [HW-1:0] hc_reg;
    logic [FW-1:0] sc_reg, vc_reg;

    always_comb
    begin
        off_ext = {{2{hue_off_reg[CW-1]}}, hue_off_reg, 8'b0};
        h1 = $signed({3'b0, h0_reg}) + off_ext;
        if (h1 < 0)
            h2 = h1 + $signed({3'b0, hsvca_pkg::HUE_FULL});
        else if (h1 > $signed({3'b0, hsvca_pkg::HUE_FULL}))
            h2 = h1 - $signed({3'b0, hsvca_pkg::HUE_FULL});
        else
            h2 = h1;
        if (h2 < 0)
            hc_next = '0;
        else if (h2 > $signed({3'b0, hsvca_pkg::HUE_FULL}))
            hc_next = hsvca_pkg::HUE_FULL;
        else
            hc_next = h2[HW-1:0];

        s_mul = 46'(sp_reg) * 46'(hsvca_pkg::RECIP100);
        v_mul = 46'(vp_reg) * 46'(hsvca_pkg::RECIP100);
        s_div = s_mul[45:hsvca_pkg::RECIP100_SH];
        v_div = v_mul[45:hsvca_pkg::RECIP100_SH];
        if (sz_reg)
            sc_next = '0;
        else if (s_div > 17'(hsvca_pkg::FX_ONE))
            sc_next = hsvca_pkg::FX_ONE;
        else
            sc_next = s_div[FW-1:0];
        if (vz_reg)
            vc_next = '0;
        else if (v_div > 17'(hsvca_pkg::FX_ONE))
            vc_next = hsvca_pkg::FX_ONE;
        else
            vc_next = v_div[FW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy_c && vld_b_reg)
        begin
            hc_reg <= hc_next;
            sc_reg <= sc_next;
            vc_reg <= vc_next;
        end
    end

    // ---------------- stage D: sector and remainder ----------------
    hsvca_pkg::hue_sector_t sec_next;
    logic [HW-1:0]          rem_full;

    hsvca_pkg::hue_sector_t sec_d_reg;
    logic [QW-1:0]          rem_d_reg;
    logic [FW-1:0]          s_d_reg, v_d_reg;

    always_comb
    begin
        rem_full = hc_reg;
        // exactly 360 degrees: last sector with zero fraction
        priority if (hc_reg == hsvca_pkg::HUE_FULL)
        begin
            sec_next = hsvca_pkg::SEC_MR;
            rem_full = '0;
        end
        else if (hc_reg >= 5 * hsvca_pkg::HUE_SECTOR)
        begin
            sec_next = hsvca_pkg::SEC_MR;
            rem_full = HW'(hc_reg - 5 * hsvca_pkg::HUE_SECTOR);
        end
        else if (hc_reg >= 4 * hsvca_pkg::HUE_SECTOR)
        begin
            sec_next = hsvca_pkg::SEC_BM;
            rem_full = HW'(hc_reg - 4 * hsvca_pkg::HUE_SECTOR);
        end
        else if (hc_reg >= 3 * hsvca_pkg::HUE_SECTOR)
        begin
            sec_next = hsvca_pkg::SEC_CB;
            rem_full = HW'(hc_reg - 3 * hsvca_pkg::HUE_SECTOR);
        end
        else if (hc_reg >= 2 * hsvca_pkg::HUE_SECTOR)
        begin
            sec_next = hsvca_pkg::SEC_GC;
            rem_full = HW'(hc_reg - 2 * hsvca_pkg::HUE_SECTOR);
        end
        else if (hc_reg >= hsvca_pkg::HUE_SECTOR)
        begin
            sec_next = hsvca_pkg::SEC_YG;
            rem_full = hc_reg - hsvca_pkg::HUE_SECTOR;
        end
        else
        begin
            sec_next = hsvca_pkg::SEC_RY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_d && vld_c_reg)
        begin
            sec_d_reg <= sec_next;
            rem_d_reg <= rem_full[QW-1:0];
            s_d_reg   <= sc_reg;
            v_d_reg   <= vc_reg;
        end
    end

    // ---------------- stage E: fraction f = rem * ONE / 15360 ----------------
    logic [15:0]   rem4;
    logic [32:0]   f_mul;

    hsvca_pkg::hue_sector_t sec_e_reg;
    logic [FW-1:0]          f_e_reg, s_e_reg, v_e_reg;

    always_comb
    begin
        // ONE / 15360 = 2^(F-10) / 15
        rem4  = 16'(rem_d_reg) << (FB - 10);
        f_mul = 33'(rem4) * 33'(hsvca_pkg::RECIP15);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_e && vld_d_reg)
        begin
            sec_e_reg <= sec_d_reg;
            f_e_reg   <= f_mul[hsvca_pkg::RECIP15_SH +: FW];
            s_e_reg   <= s_d_reg;
            v_e_reg   <= v_d_reg;
        end
    end

    // ---------------- stage F: s*f, s*(1-f), p ----------------
    logic [2*FW-1:0] sf_mul, sfc_mul, p_mul;

    hsvca_pkg::hue_sector_t sec_f_reg;
    logic [FW-1:0]          sf_f_reg, sfc_f_reg, p_f_reg, v_f_reg;

    always_comb
    begin
        sf_mul  = (2*FW)'(s_e_reg) * (2*FW)'(f_e_reg);
        sfc_mul = (2*FW)'(s_e_reg) * (2*FW)'(hsvca_pkg::FX_ONE - f_e_reg);
        p_mul   = (2*FW)'(v_e_reg) * (2*FW)'(hsvca_pkg::FX_ONE - s_e_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_f && vld_e_reg)
        begin
            sec_f_reg <= sec_e_reg;
            sf_f_reg  <= sf_mul[FB +: FW];
            sfc_f_reg <= sfc_mul[FB +: FW];
            p_f_reg   <= p_mul[FB +: FW];
            v_f_reg   <= v_e_reg;
        end
    end

    // ---------------- stage G: q and t ----------------
    logic [2*FW-1:0] q_mul, t_mul;

    hsvca_pkg::hue_sector_t sec_g_reg;
    logic [FW-1:0]          p_g_reg, q_g_reg, t_g_reg, v_g_reg;

    always_comb
    begin
        q_mul = (2*FW)'(v_f_reg) * (2*FW)'(hsvca_pkg::FX_ONE - sf_f_reg);
        t_mul = (2*FW)'(v_f_reg) * (2*FW)'(hsvca_pkg::FX_ONE - sfc_f_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_g && vld_f_reg)
        begin
            sec_g_reg <= sec_f_reg;
            p_g_reg   <= p_f_reg;
            q_g_reg   <= q_mul[FB +: FW];
            t_g_reg   <= t_mul[FB +: FW];
            v_g_reg   <= v_f_reg;
        end
    end

    // ---------------- stage H: sector select, scale to 8 bits ----------------
    logic [FW-1:0]  ro, go, bo;
    logic [FW+7:0]  rx, gx, bx;
    logic [7:0]     red_reg, green_reg, blue_reg;

    always_comb
    begin
        unique case (sec_g_reg)
            hsvca_pkg::SEC_RY: begin ro = v_g_reg; go = t_g_reg; bo = p_g_reg; end
            hsvca_pkg::SEC_YG: begin ro = q_g_reg; go = v_g_reg; bo = p_g_reg; end
            hsvca_pkg::SEC_GC: begin ro = p_g_reg; go = v_g_reg; bo = t_g_reg; end
            hsvca_pkg::SEC_CB: begin ro = p_g_reg; go = q_g_reg; bo = v_g_reg; end
            hsvca_pkg::SEC_BM: begin ro = t_g_reg; go = p_g_reg; bo = v_g_reg; end
            default:           begin ro = v_g_reg; go = p_g_reg; bo = q_g_reg; end
        endcase
        // x * 255 = (x << 8) - x
        rx = ((FW+8)'(ro) << 8) - (FW+8)'(ro);
        gx = ((FW+8)'(go) << 8) - (FW+8)'(go);
        bx = ((FW+8)'(bo) << 8) - (FW+8)'(bo);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_h && vld_g_reg)
        begin
            red_reg   <= rx[FB +: 8];
            green_reg <= gx[FB +: 8];
            blue_reg  <= bx[FB +: 8];
        end
    end

    assign out_valid = vld_h_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

// ===== sv/hsvca_div_cell.sv =====
// One cell of the divider chain: one restoring step on each of two lanes.
`timescale 1ns / 1ps
module hsvca_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_vld,
    input  hsvca_pkg::div_word_t  in_word,
    input  logic                  down_rdy,
    output logic                  up_rdy,
    output logic                  out_vld,
    output hsvca_pkg::div_word_t  out_word
);

    logic                 vld_reg;
    hsvca_pkg::div_word_t word_reg;
    hsvca_pkg::div_word_t word_next;

    function automatic hsvca_pkg::div_lane_t div_step(input hsvca_pkg::div_lane_t a);
        hsvca_pkg::div_lane_t       r;
        logic [hsvca_pkg::REM_W:0]  trial;
        logic [hsvca_pkg::REM_W:0]  diff;
        logic                       ge;
        r     = a;
        trial = {a.rem, a.nlow[hsvca_pkg::QUO_W-1]};
        diff  = trial - {1'b0, a.dvs};
        ge    = (trial >= {1'b0, a.dvs});
        r.rem  = ge ? diff[hsvca_pkg::REM_W-1:0] : trial[hsvca_pkg::REM_W-1:0];
        r.nlow = {a.nlow[hsvca_pkg::QUO_W-2:0], 1'b0};
        r.quo  = {a.quo[hsvca_pkg::QUO_W-2:0], ge};
        return r;
    endfunction

    assign up_rdy = !vld_reg || down_rdy;

    always_comb
    begin
        word_next      = in_word;
        word_next.sat  = div_step(in_word.sat);
        word_next.hue  = div_step(in_word.hue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (up_rdy)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_rdy && in_vld)
        begin
            word_reg <= word_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_word = word_reg;

endmodule

// ===== sv/hsvca_checker.sv =====
// Port-level checks for the HSV color adjust unit, bound to the top level.
`timescale 1ns / 1ps
module hsvca_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [7:0]                  red_out,
    input logic [7:0]                  green_out,
    input logic [7:0]                  blue_out
);

    // a result offered and stalled is still offered next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({red_out, green_out, blue_out}))
        else $error("output pixel changed while stalled");

    // the input only backs up once the output itself is held
    assert property (@(posedge clk)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output not blocked");

    assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_stall)
        else $error("pipeline not empty in reset");

endmodule

bind hsv_color_adjust_unit hsvca_checker u_hsvca_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the HSV color adjust unit.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    // Predicts adjusted pixels and checks them in order.
    class pixel_scoreboard;
        pixel_t     pending[$];
        int         errors;
        int         hue_deg;
        int         sat_pct;
        int         val_pct;

        function longint fdiv(longint num, longint den);
            if (num >= 0)
                return num / den;
            return -((-num + den - 1) / den);
        endfunction

        function longint scale(longint x, int pct);
            longint k;
            longint r;
            k = 100 + pct;
            if (k <= 0)
                return 0;
            r = (x * k) / 100;
            return (r > 4096) ? 4096 : r;
        endfunction

        function logic [7:0] chan(longint x);
            if (x < 0)
                x = 0;
            if (x > 4096)
                x = 4096;
            return 8'((x * 255) >> 12);
        endfunction

        function pixel_t adjust(pixel_t px);
            longint r, g, b, mx, mn, dl, h, s, v, sec, rem, f, p, q, t;
            pixel_t o;
            r = px.r; g = px.g; b = px.b;
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            dl = mx - mn;
            h = 0; s = 0; v = 0;
            if (mx != 0) begin
                v = (mx * 4096 + 254) / 255;
                s = (dl * 4096 + mx - 1) / mx;
                if (dl != 0) begin
                    if (r == mx) begin
                        h = fdiv((g - b) * 15360, dl);
                        if (h < 0)
                            h += 92160;
                    end else if (g == mx)
                        h = 30720 + fdiv((b - r) * 15360, dl);
                    else
                        h = 61440 + fdiv((r - g) * 15360, dl);
                end
            end
            h += longint'(hue_deg) * 256;
            s = scale(s, sat_pct);
            v = scale(v, val_pct);
            if (h < 0)
                h += 92160;
            else if (h > 92160)
                h -= 92160;
            if (h < 0)
                h = 0;
            if (h > 92160)
                h = 92160;
            sec = h / 15360;
            rem = h - sec * 15360;
            f = (rem * 4096) / 15360;
            p = (v * (4096 - s)) >>> 12;
            q = (v * (4096 - ((s * f) >>> 12))) >>> 12;
            t = (v * (4096 - ((s * (4096 - f)) >>> 12))) >>> 12;
            case (sec)
                0: begin o.r = chan(v); o.g = chan(t); o.b = chan(p); end
                1: begin o.r = chan(q); o.g = chan(v); o.b = chan(p); end
                2: begin o.r = chan(p); o.g = chan(v); o.b = chan(t); end
                3: begin o.r = chan(p); o.g = chan(q); o.b = chan(v); end
                4: begin o.r = chan(t); o.g = chan(p); o.b = chan(v); end
                default: begin o.r = chan(v); o.g = chan(p); o.b = chan(q); end
            endcase
            return o;
        endfunction

        function void note_input(pixel_t px);
            pending.push_back(adjust(px));
        endfunction

        function void check_output(pixel_t got);
            pixel_t exp_px;
            if (pending.size() == 0) begin
                $display("%0t: unexpected pixel %0d %0d %0d", $time, got.r, got.g, got.b);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.r !== exp_px.r) begin
                $display("%0t: red expected %0d actual %0d", $time, exp_px.r, got.r);
                errors++;
            end
            if (got.g !== exp_px.g) begin
                $display("%0t: green expected %0d actual %0d", $time, exp_px.g, got.g);
                errors++;
            end
            if (got.b !== exp_px.b) begin
                $display("%0t: blue expected %0d actual %0d", $time, exp_px.b, got.b);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n;
    logic       in_valid = 0;
    logic       in_stall;
    logic [7:0] red_in = 0, green_in = 0, blue_in = 0;
    logic       out_valid;
    logic       out_stall = 0;
    logic [7:0] red_out, green_out, blue_out;
    logic       cfg_we = 0;
    logic [1:0] cfg_index = 0;
    logic [hsvca_pkg::CFG_W-1:0] cfg_data = 0;

    pixel_scoreboard sb = new();
    int  idle_cycles = 0;

    always #6 clk = ~clk;

    hsv_color_adjust_unit dut (.*);

    // sample transfers and run the watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_input('{red_in, green_in, blue_in});
            if (out_valid && !out_stall)
                sb.check_output('{red_out, green_out, blue_out});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > 3000) begin
                $display("hsv_color_adjust_unit test failed");
                $finish;
            end
        end
    end

    // receiver: random stall per transfer, with calm stretches
    initial begin
        int n;
        int calm;
        calm = 0;
        forever begin
            @(negedge clk);
            if (calm > 0) begin
                calm--;
                out_stall <= 0;
            end else begin
                n = $urandom_range(0, 12);
                if ($urandom_range(0, 9) == 0)
                    calm = $urandom_range(20, 80);
                else if (n > 0) begin
                    out_stall <= 1;
                    repeat (n) @(negedge clk);
                end
                out_stall <= 0;
            end
            while (!(out_valid && !out_stall)) @(negedge clk);
        end
    end

    task automatic write_cfg(hsvca_pkg::cfg_reg_t idx, int val);
        @(negedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= hsvca_pkg::CFG_W'(val);
        @(negedge clk);
        cfg_we    <= 0;
        sb.hue_deg = (idx == hsvca_pkg::CFG_HUE_OFFSET) ? val : sb.hue_deg;
        sb.sat_pct = (idx == hsvca_pkg::CFG_SAT_PCT) ? val : sb.sat_pct;
        sb.val_pct = (idx == hsvca_pkg::CFG_VAL_PCT) ? val : sb.val_pct;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // gap holds valid low before this transfer
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, int gap);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int count, bit bursty);
        int gap;
        for (int i = 0; i < count; i++) begin
            gap = bursty ? 0 : $urandom_range(0, 12);
            if (!bursty && $urandom_range(0, 3) == 0)
                gap = 0;
            case ($urandom_range(0, 5))
                0: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gap);
                1: begin
                    // grey
                    int x;
                    x = $urandom_range(0, 255);
                    send_pixel(8'(x), 8'(x), 8'(x), gap);
                end
                2: begin
                    // ties for largest channel
                    int x;
                    x = $urandom_range(0, 255);
                    send_pixel(8'(x), 8'(x), 8'($urandom_range(0, x)), gap);
                end
                default: send_pixel(8'($urandom), 8'($urandom), 8'($urandom), gap);
            endcase
        end
        in_valid <= 0;
    endtask

    initial begin
        int hues[5] = '{0, 360, -360, 90, -150};
        int pcts[5] = '{0, 300, -100, 40, -60};
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: extremes, grey, black, ties, hue 360 boundary
        send_pixel(8'd0, 8'd0, 8'd0, 0);
        send_pixel(8'd255, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd0, 0);
        send_pixel(8'd0, 8'd255, 8'd0, 0);
        send_pixel(8'd0, 8'd0, 8'd255, 0);
        send_pixel(8'd255, 8'd255, 8'd0, 1);
        send_pixel(8'd0, 8'd255, 8'd255, 0);
        send_pixel(8'd255, 8'd0, 8'd255, 0);
        send_pixel(8'd128, 8'd128, 8'd128, 2);
        send_pixel(8'd255, 8'd0, 8'd1, 0);
        send_pixel(8'd1, 8'd0, 8'd0, 0);
        send_pixel(8'd170, 8'd85, 8'd85, 0);
        in_valid <= 0;
        drain();
        write_cfg(hsvca_pkg::CFG_HUE_OFFSET, 1);
        send_pixel(8'd255, 8'd0, 8'd1, 0);   // hue wraps past 360
        send_pixel(8'd200, 8'd10, 8'd100, 0);
        in_valid <= 0;
        drain();
        // out-of-range codes: hue wraps or clamps, saturation and value saturate
        write_cfg(hsvca_pkg::CFG_HUE_OFFSET, 511);
        write_cfg(hsvca_pkg::CFG_SAT_PCT, -512);
        write_cfg(hsvca_pkg::CFG_VAL_PCT, 511);
        send_random(20, 0);
        drain();
        write_cfg(hsvca_pkg::CFG_HUE_OFFSET, -512);
        write_cfg(hsvca_pkg::CFG_SAT_PCT, 511);
        write_cfg(hsvca_pkg::CFG_VAL_PCT, -101);
        send_random(20, 0);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            write_cfg(hsvca_pkg::CFG_HUE_OFFSET,
                      (ph < 5) ? hues[ph] : $urandom_range(0, 720) - 360);
            write_cfg(hsvca_pkg::CFG_SAT_PCT,
                      (ph < 5) ? pcts[ph] : $urandom_range(0, 400) - 100);
            write_cfg(hsvca_pkg::CFG_VAL_PCT,
                      (ph < 5) ? pcts[4 - ph] : $urandom_range(0, 400) - 100);
            send_random(60, ph == 3);
            drain();   // sender waits for all results
            send_random(65, 0);
            drain();
        end

        if (sb.errors == 0)
            $display("hsv_color_adjust_unit test passed");
        else
            $display("hsv_color_adjust_unit test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/hsvca_pkg.sv
sv/hsvca_div_cell.sv
sv/hsv_color_adjust_unit.sv
sv/hsvca_checker.sv
tb/testbench.sv
